[sv/bed_genotype_unpacker_macros.svh]
// Assertion helpers for the unpacker modules; only bgu_back uses them.
// Each expects signals named clk and rst_n in the module that uses it.
`ifndef BED_GENOTYPE_UNPACKER_MACROS_SVH
`define BED_GENOTYPE_UNPACKER_MACROS_SVH

`define BGU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BGU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/bgu_pkg.sv]
package bgu_pkg;

    localparam int DATA_W     = 8;
    localparam int GENO_W     = 2;
    localparam int ROW_IDX_W  = 16;
    localparam int COL_IDX_W  = 24;
    localparam int STATUS_W   = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 25;
    localparam int ROWS_REG_W = 17;
    localparam int COLS_REG_W = 25;

    localparam logic [CFG_INDEX_W-1:0] REG_NUM_ROWS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_COLS = 2'd1;

    localparam logic [DATA_W-1:0] MAGIC_FIRST  = 8'h6C;
    localparam logic [DATA_W-1:0] MAGIC_SECOND = 8'h1B;

    localparam logic [1:0] HDR_FIRST  = 2'd0;
    localparam logic [1:0] HDR_SECOND = 2'd1;
    localparam logic [1:0] HDR_ORDER  = 2'd2;
    localparam logic [1:0] HDR_DONE   = 2'd3;

    localparam logic [1:0] CODE_LAST_POS = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_MAGIC = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TRUNCATED = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_DATA,
        CMD_BAD_MAGIC,
        CMD_HDR_TRUNC
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [DATA_W-1:0] data;
        logic              eof;
    } q_entry_t;

    function automatic logic [GENO_W-1:0] geno_map(input logic [1:0] code);
        logic [GENO_W-1:0] g;
        unique case (code)
            2'd0: g = 2'h2;
            2'd1: g = 2'h3;
            2'd2: g = 2'h1;
            2'd3: g = 2'h0;
            default: g = 2'h0;
        endcase
        return g;
    endfunction

endpackage

[sv/bgu_front.sv]
module bgu_front
    import bgu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] data_byte,
    input  logic              end_of_file,
    input  logic              push_ready,
    output logic              push_valid,
    output q_entry_t          push_entry,
    output logic              order_row_first
);

    logic [1:0] hdr_count_reg;
    logic [1:0] hdr_count_next;
    logic       order_reg;
    logic       order_next;
    logic       hdr_failed_reg;
    logic       hdr_failed_next;
    logic       accept;
    logic       bad_magic;

    assign in_ready        = push_ready;
    assign accept          = in_valid && push_ready;
    assign order_row_first = order_reg;

    assign bad_magic = ((hdr_count_reg == HDR_FIRST) && (data_byte != MAGIC_FIRST)) ||
                       ((hdr_count_reg == HDR_SECOND) && (data_byte != MAGIC_SECOND));

    always_comb
    begin
        hdr_count_next  = hdr_count_reg;
        order_next      = order_reg;
        hdr_failed_next = hdr_failed_reg;
        push_valid      = 1'b0;
        push_entry.kind = CMD_DATA;
        push_entry.data = data_byte;
        push_entry.eof  = end_of_file;
        priority if (!accept || hdr_failed_reg)
        begin
            push_valid = 1'b0;
        end
        else if (hdr_count_reg != HDR_DONE)
        begin
            if (bad_magic)
            begin
                push_valid      = 1'b1;
                push_entry.kind = CMD_BAD_MAGIC;
                hdr_failed_next = 1'b1;
            end
            else
            begin
                if (hdr_count_reg == HDR_ORDER)
                begin
                    order_next = (data_byte != '0);
                end
                hdr_count_next = hdr_count_reg + 2'd1;
                if (end_of_file)
                begin
                    push_valid      = 1'b1;
                    push_entry.kind = CMD_HDR_TRUNC;
                    hdr_failed_next = 1'b1;
                end
            end
        end
        else
        begin
            push_valid = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_count_reg  <= HDR_FIRST;
            order_reg      <= 1'b0;
            hdr_failed_reg <= 1'b0;
        end
        else
        begin
            hdr_count_reg  <= hdr_count_next;
            order_reg      <= order_next;
            hdr_failed_reg <= hdr_failed_next;
        end
    end

endmodule

[sv/bgu_queue.sv]
module bgu_queue
    import bgu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    input  q_entry_t push_entry,
    output logic     push_ready,
    output logic     pop_valid,
    output q_entry_t pop_entry,
    input  logic     pop_ready
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t         entries [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[sv/bgu_back.sv]
`include "bed_genotype_unpacker_macros.svh"

module bgu_back
    import bgu_pkg::*;
#(
    parameter int ROW_CW = 17,
    parameter int COL_CW = 25
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    input  q_entry_t             pop_entry,
    output logic                 pop_ready,
    input  logic                 order_row_first,
    input  logic [ROW_CW-1:0]    rows_lim,
    input  logic [COL_CW-1:0]    cols_lim,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [GENO_W-1:0]    genotype,
    output logic [ROW_IDX_W-1:0] row_index,
    output logic [COL_IDX_W-1:0] col_index,
    output logic [STATUS_W-1:0]  status,
    output logic                 last_of_byte,
    output logic                 matrix_done
);

    logic              busy_reg;
    logic              busy_next;
    cmd_kind_t         kind_reg;
    cmd_kind_t         kind_next;
    logic [1:0]        pos_reg;
    logic [1:0]        pos_next;
    logic [ROW_CW-1:0] row_cnt_reg;
    logic [ROW_CW-1:0] row_cnt_next;
    logic [COL_CW-1:0] col_cnt_reg;
    logic [COL_CW-1:0] col_cnt_next;
    logic              fin_reg;
    logic              fin_next;
    logic              fail_reg;
    logic              fail_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] byte_reg;
    logic              eof_reg;

    logic [GENO_W-1:0]    geno_reg;
    logic [ROW_IDX_W-1:0] row_idx_reg;
    logic [COL_IDX_W-1:0] col_idx_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic                 last_reg;
    logic                 done_reg;

    logic [ROW_CW-1:0]    row_inc;
    logic [COL_CW-1:0]    col_inc;
    logic                 row_wrap;
    logic                 col_wrap;
    logic                 line_end;
    logic                 done_w;
    logic [ROW_CW-1:0]    row_step;
    logic [COL_CW-1:0]    col_step;
    logic                 is_data;
    logic                 drop;
    logic                 advance;
    logic                 emit;
    logic                 data_last;
    logic                 item_end;
    logic                 load;

    logic [GENO_W-1:0]    res_geno;
    logic [ROW_IDX_W-1:0] res_row;
    logic [COL_IDX_W-1:0] res_col;
    logic [STATUS_W-1:0]  res_status;
    logic                 res_done;

    assign is_data   = (kind_reg == CMD_DATA);
    assign drop      = is_data && (fin_reg || fail_reg);
    assign advance   = busy_reg && (drop || !out_valid_reg || out_ready);
    assign emit      = advance && !drop;

    assign row_inc  = row_cnt_reg + ROW_CW'(1);
    assign col_inc  = col_cnt_reg + COL_CW'(1);
    assign row_wrap = (row_inc >= rows_lim);
    assign col_wrap = (col_inc >= cols_lim);

    always_comb
    begin
        if (order_row_first)
        begin
            line_end = row_wrap;
            done_w   = row_wrap && col_wrap;
            row_step = row_wrap ? '0 : row_inc;
            col_step = row_wrap ? col_inc : col_cnt_reg;
        end
        else
        begin
            line_end = col_wrap;
            done_w   = col_wrap && row_wrap;
            col_step = col_wrap ? '0 : col_inc;
            row_step = col_wrap ? row_inc : row_cnt_reg;
        end
    end

    assign data_last = line_end || (pos_reg == CODE_LAST_POS);
    assign item_end  = drop || !is_data || data_last;
    assign pop_ready = !busy_reg || (advance && item_end);
    assign load      = pop_valid && pop_ready;

    always_comb
    begin
        res_geno   = '0;
        res_row    = '0;
        res_col    = '0;
        res_status = STATUS_OK;
        res_done   = 1'b0;
        unique case (kind_reg)
            CMD_DATA:
            begin
                res_geno   = geno_map(byte_reg[1:0]);
                res_row    = ROW_IDX_W'(row_cnt_reg);
                res_col    = COL_IDX_W'(col_cnt_reg);
                res_done   = done_w;
                res_status = (data_last && eof_reg && !done_w) ? STATUS_TRUNCATED : STATUS_OK;
            end
            CMD_BAD_MAGIC:
            begin
                res_status = STATUS_BAD_MAGIC;
            end
            CMD_HDR_TRUNC:
            begin
                res_status = STATUS_TRUNCATED;
            end
            default:
            begin
                res_status = STATUS_OK;
            end
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        kind_next      = kind_reg;
        pos_next       = pos_reg;
        row_cnt_next   = row_cnt_reg;
        col_cnt_next   = col_cnt_reg;
        fin_next       = fin_reg;
        fail_next      = fail_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        if (emit && is_data)
        begin
            pos_next     = pos_reg + 2'd1;
            row_cnt_next = row_step;
            col_cnt_next = col_step;
            fin_next     = fin_reg || done_w;
            fail_next    = fail_reg || (data_last && eof_reg && !done_w);
        end
        if (advance && item_end)
        begin
            busy_next = 1'b0;
            pos_next  = '0;
        end
        if (load)
        begin
            busy_next = 1'b1;
            kind_next = pop_entry.kind;
            pos_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            kind_reg      <= CMD_DATA;
            pos_reg       <= '0;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            fin_reg       <= 1'b0;
            fail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            kind_reg      <= kind_next;
            pos_reg       <= pos_next;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            fin_reg       <= fin_next;
            fail_reg      <= fail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= pop_entry.data;
            eof_reg  <= pop_entry.eof;
        end
        else if (emit && is_data)
        begin
            byte_reg <= byte_reg >> 2;
        end
        if (emit)
        begin
            geno_reg    <= res_geno;
            row_idx_reg <= res_row;
            col_idx_reg <= res_col;
            status_reg  <= res_status;
            last_reg    <= !is_data || data_last;
            done_reg    <= res_done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign genotype     = geno_reg;
    assign row_index    = row_idx_reg;
    assign col_index    = col_idx_reg;
    assign status       = status_reg;
    assign last_of_byte = last_reg;
    assign matrix_done  = done_reg;

    `BGU_ASSERT_NEXT(a_done_sets_finished, emit && is_data && done_w, fin_reg, "Final element did not stop the stream")
    `BGU_ASSERT_IMP(a_done_is_last, out_valid_reg && done_reg, last_reg, "Final element not marked last of byte")
    `BGU_ASSERT_IMP(a_trunc_is_last, out_valid_reg && (status_reg == STATUS_TRUNCATED), last_reg, "Truncation status on a result that is not last")
    `BGU_ASSERT_IMP(a_pos_needs_busy, pos_reg != 2'd0, busy_reg, "Code position advanced with no byte in hand")

endmodule

[sv/bed_genotype_unpacker.sv]
// Unpacks a 2-bit packed genotype file taken one byte per request. The first two bytes are
// checked as magic, the third selects the order, and each later byte yields one to four
// genotype results, one per cycle while out_ready is high, each tagged with its row and
// column; a result with status bad magic or truncated ends the stream until reset, and
// after the final matrix element further bytes are taken and dropped. A data byte holds
// the result stage until its last result is passed on, a header byte that ends the stream
// or a dropped byte passes through once, and any other header byte never enters it; that
// single result stage behind a two-entry request queue sets the rate, so the input side
// takes a new byte while earlier results are still being delivered. Both size registers are
// clamped when written: zero acts as one and values above the bounds act as the bounds.
module bed_genotype_unpacker
    import bgu_pkg::*;
#(
    parameter int MAX_ROWS = 65536,
    parameter int MAX_COLS = 16777216
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [DATA_W-1:0]      data_byte,
    input  logic                   end_of_file,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [GENO_W-1:0]      genotype,
    output logic [ROW_IDX_W-1:0]   row_index,
    output logic [COL_IDX_W-1:0]   col_index,
    output logic [STATUS_W-1:0]    status,
    output logic                   last_of_byte,
    output logic                   matrix_done
);

    localparam int ROW_CW = $clog2(MAX_ROWS + 1);
    localparam int COL_CW = $clog2(MAX_COLS + 1);

    logic [ROW_CW-1:0] rows_lim_reg;
    logic [ROW_CW-1:0] rows_lim_next;
    logic [COL_CW-1:0] cols_lim_reg;
    logic [COL_CW-1:0] cols_lim_next;
    logic [31:0]       rows_val;
    logic [31:0]       cols_val;
    logic [31:0]       rows_clamped;
    logic [31:0]       cols_clamped;
    logic              cfg_write;

    logic     push_valid;
    logic     push_ready;
    q_entry_t push_entry;
    logic     pop_valid;
    logic     pop_ready;
    q_entry_t pop_entry;
    logic     order_row_first;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign rows_val = 32'(cfg_data[ROWS_REG_W-1:0]);
    assign cols_val = 32'(cfg_data[COLS_REG_W-1:0]);

    always_comb
    begin
        priority if (rows_val == 32'd0)
        begin
            rows_clamped = 32'd1;
        end
        else if (rows_val > 32'(MAX_ROWS))
        begin
            rows_clamped = 32'(MAX_ROWS);
        end
        else
        begin
            rows_clamped = rows_val;
        end
        priority if (cols_val == 32'd0)
        begin
            cols_clamped = 32'd1;
        end
        else if (cols_val > 32'(MAX_COLS))
        begin
            cols_clamped = 32'(MAX_COLS);
        end
        else
        begin
            cols_clamped = cols_val;
        end
        rows_lim_next = rows_lim_reg;
        cols_lim_next = cols_lim_reg;
        if (cfg_write && (cfg_index == REG_NUM_ROWS))
        begin
            rows_lim_next = ROW_CW'(rows_clamped);
        end
        if (cfg_write && (cfg_index == REG_NUM_COLS))
        begin
            cols_lim_next = COL_CW'(cols_clamped);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_lim_reg <= ROW_CW'(1);
            cols_lim_reg <= COL_CW'(1);
        end
        else
        begin
            rows_lim_reg <= rows_lim_next;
            cols_lim_reg <= cols_lim_next;
        end
    end

    bgu_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .end_of_file     (end_of_file),
        .push_ready      (push_ready),
        .push_valid      (push_valid),
        .push_entry      (push_entry),
        .order_row_first (order_row_first)
    );

    bgu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    bgu_back #(
        .ROW_CW (ROW_CW),
        .COL_CW (COL_CW)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .pop_valid       (pop_valid),
        .pop_entry       (pop_entry),
        .pop_ready       (pop_ready),
        .order_row_first (order_row_first),
        .rows_lim        (rows_lim_reg),
        .cols_lim        (cols_lim_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .genotype        (genotype),
        .row_index       (row_index),
        .col_index       (col_index),
        .status          (status),
        .last_of_byte    (last_of_byte),
        .matrix_done     (matrix_done)
    );

endmodule

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bgu_pkg::*;

    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 9;
    localparam int SETTLE_CYCLES    = 10;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RUN_LIMIT_CYCLES = 400000;

    localparam int unsigned ROWS_BOUND = 65536;
    localparam int unsigned COLS_BOUND = 16777216;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [63:0] CORNER_BYTES = 64'h00FF_55AA_E41B_0FF0;

    typedef enum {
        END_BAD_FIRST,
        END_BAD_SECOND,
        END_HDR_EOF,
        END_TRUNCATED,
        END_COMPLETE
    } stream_end_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              eof;
    } file_byte_t;

    typedef struct packed {
        logic [GENO_W-1:0]    genotype;
        logic [ROW_IDX_W-1:0] row_idx;
        logic [COL_IDX_W-1:0] col_idx;
        logic [STATUS_W-1:0]  status;
        logic                 last_of_byte;
        logic                 matrix_done;
    } geno_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [DATA_W-1:0]      data_byte = '0;
    logic                   end_of_file = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [GENO_W-1:0]      genotype;
    logic [ROW_IDX_W-1:0]   row_index;
    logic [COL_IDX_W-1:0]   col_index;
    logic [STATUS_W-1:0]    status;
    logic                   last_of_byte;
    logic                   matrix_done;

    file_byte_t   pending_bytes[$];
    geno_result_t expected_genos[$];

    int bytes_queued    = 0;
    int bytes_accepted  = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int long_hold_len   = 0;
    int rx_held         = 0;

    stream_end_t ending;
    logic        row_fastest;

    logic [1:0]            hdr_seen = HDR_FIRST;
    logic                  rows_inner = 1'b0;
    int unsigned           row_ctr = 0;
    int unsigned           col_ctr = 0;
    logic                  matrix_complete = 1'b0;
    logic                  stream_halted = 1'b0;
    logic [ROWS_REG_W-1:0] rows_reg = ROWS_REG_W'(1);
    logic [COLS_REG_W-1:0] cols_reg = COLS_REG_W'(1);

    bed_genotype_unpacker i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .end_of_file  (end_of_file),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .genotype     (genotype),
        .row_index    (row_index),
        .col_index    (col_index),
        .status       (status),
        .last_of_byte (last_of_byte),
        .matrix_done  (matrix_done)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [GENO_W-1:0] code_to_genotype(input logic [1:0] code);
        logic [GENO_W-1:0] g;
        case (code)
            2'd0:    g = 2'd2;
            2'd1:    g = 2'd3;
            2'd2:    g = 2'd1;
            default: g = 2'd0;
        endcase
        return g;
    endfunction

    function automatic int unsigned limit_of(input int unsigned v, input int unsigned bound);
        if (v == 0)
        begin
            return 1;
        end
        if (v > bound)
        begin
            return bound;
        end
        return v;
    endfunction

    task automatic decode_byte(input logic [DATA_W-1:0] b, input logic eof);
        geno_result_t r;
        int unsigned  rows_lim;
        int unsigned  cols_lim;
        logic         line_end;
        if (stream_halted || matrix_complete)
        begin
            return;
        end
        r = '0;
        if (hdr_seen != HDR_DONE)
        begin
            if ((hdr_seen == HDR_FIRST && b != MAGIC_FIRST) ||
                (hdr_seen == HDR_SECOND && b != MAGIC_SECOND))
            begin
                stream_halted = 1'b1;
                r.status = STATUS_BAD_MAGIC;
                r.last_of_byte = 1'b1;
                expected_genos = {expected_genos, r};
                return;
            end
            if (hdr_seen == HDR_ORDER)
            begin
                rows_inner = (b != '0);
            end
            hdr_seen = hdr_seen + 2'd1;
            if (eof)
            begin
                stream_halted = 1'b1;
                r.status = STATUS_TRUNCATED;
                r.last_of_byte = 1'b1;
                expected_genos = {expected_genos, r};
            end
            return;
        end
        rows_lim = limit_of(32'(rows_reg), ROWS_BOUND);
        cols_lim = limit_of(32'(cols_reg), COLS_BOUND);
        for (int pos = 0; pos < 4; pos++)
        begin
            r = '0;
            r.genotype = code_to_genotype(b[2*pos +: 2]);
            r.row_idx = row_ctr[ROW_IDX_W-1:0];
            r.col_idx = col_ctr[COL_IDX_W-1:0];
            line_end = 1'b0;
            if (rows_inner)
            begin
                row_ctr++;
                if (row_ctr >= rows_lim)
                begin
                    row_ctr = 0;
                    col_ctr++;
                    line_end = 1'b1;
                    matrix_complete = (col_ctr >= cols_lim);
                end
            end
            else
            begin
                col_ctr++;
                if (col_ctr >= cols_lim)
                begin
                    col_ctr = 0;
                    row_ctr++;
                    line_end = 1'b1;
                    matrix_complete = (row_ctr >= rows_lim);
                end
            end
            if (line_end || pos == 3)
            begin
                r.last_of_byte = 1'b1;
                r.matrix_done = matrix_complete;
                if (eof && !matrix_complete)
                begin
                    r.status = STATUS_TRUNCATED;
                    stream_halted = 1'b1;
                end
                expected_genos = {expected_genos, r};
                break;
            end
            expected_genos = {expected_genos, r};
        end
    endtask

    function automatic void check_field(input string field, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            mismatches++;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : byte_driver
        file_byte_t nxt;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                decode_byte(data_byte, end_of_file);
                bytes_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_bytes.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= nxt.data;
                    end_of_file <= nxt.eof;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        geno_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_genos.size() == 0)
                begin
                    mismatches++;
                    $error("unexpected result: genotype %0d row %0d col %0d status %0d",
                           genotype, row_index, col_index, status);
                end
                else
                begin
                    want = expected_genos.pop_front();
                    check_field("genotype", 64'(want.genotype), 64'(genotype));
                    check_field("row_index", 64'(want.row_idx), 64'(row_index));
                    check_field("col_index", 64'(want.col_idx), 64'(col_index));
                    check_field("status", 64'(want.status), 64'(status));
                    check_field("last_of_byte", 64'(want.last_of_byte), 64'(last_of_byte));
                    check_field("matrix_done", 64'(want.matrix_done), 64'(matrix_done));
                    results_checked++;
                end
            end
            if (rx_held < long_hold_len)
            begin
                rx_held++;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_NUM_ROWS)
        begin
            rows_reg = value[ROWS_REG_W-1:0];
        end
        else if (idx == REG_NUM_COLS)
        begin
            cols_reg = value[COLS_REG_W-1:0];
        end
    endtask

    // The inner dimension is the one whose index runs fastest within a line.
    task automatic set_shape(input logic [CFG_DATA_W-1:0] inner,
                             input logic [CFG_DATA_W-1:0] outer);
        if (row_fastest)
        begin
            write_reg(REG_NUM_ROWS, inner);
            write_reg(REG_NUM_COLS, outer);
        end
        else
        begin
            write_reg(REG_NUM_COLS, inner);
            write_reg(REG_NUM_ROWS, outer);
        end
    endtask

    task automatic push_byte(input logic [DATA_W-1:0] d, input logic eof);
        file_byte_t fb;
        fb.data = d;
        fb.eof = eof;
        pending_bytes = {pending_bytes, fb};
        bytes_queued++;
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            push_byte(DATA_W'($urandom_range(255)), 1'b0);
        end
    endtask

    task automatic wait_drained();
        while (bytes_accepted != bytes_queued || expected_genos.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                sel;
        int unsigned       ic;
        int unsigned       oc;
        int unsigned       inner;
        int unsigned       span;
        int                k;
        int                needed;
        int                lines;
        int                last_at;
        int                hdr_end;
        logic [DATA_W-1:0] order_byte;
        logic [DATA_W-1:0] bad;
        logic [DATA_W-1:0] hdr [3];

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        sel = $urandom_range(11);
        case (sel)
            0:       ending = END_BAD_FIRST;
            1:       ending = END_BAD_SECOND;
            2:       ending = END_HDR_EOF;
            3, 4, 5: ending = END_TRUNCATED;
            default: ending = END_COMPLETE;
        endcase
        row_fastest = 1'($urandom_range(1));
        order_byte = row_fastest ? DATA_W'($urandom_range(1, 255)) : '0;
        hdr[0] = MAGIC_FIRST;
        hdr[1] = MAGIC_SECOND;
        hdr[2] = order_byte;

        set_shape(CFG_DATA_W'(5), CFG_DATA_W'(1000));
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));

        bad = DATA_W'($urandom_range(255));
        case (ending)
            END_BAD_FIRST:
            begin
                if (bad == MAGIC_FIRST)
                begin
                    bad = ~bad;
                end
                push_byte(bad, 1'($urandom_range(1)));
            end
            END_BAD_SECOND:
            begin
                if (bad == MAGIC_SECOND)
                begin
                    bad = ~bad;
                end
                push_byte(MAGIC_FIRST, 1'b0);
                push_byte(bad, 1'($urandom_range(1)));
            end
            END_HDR_EOF:
            begin
                hdr_end = $urandom_range(2);
                for (int i = 0; i <= hdr_end; i++)
                begin
                    push_byte(hdr[i], i == hdr_end);
                end
            end
            default:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    push_byte(hdr[i], 1'b0);
                end
            end
        endcase

        for (int i = 7; i >= 0; i--)
        begin
            push_byte(CORNER_BYTES[8*i +: 8], 1'b0);
        end
        send_random(10);
        wait_drained();

        set_shape('0, '1);
        send_idle_pct = 68;
        recv_stall_pct = 0;
        send_random(25);
        wait_drained();

        set_shape('1, row_fastest ? CFG_DATA_W'(COLS_BOUND) : CFG_DATA_W'(ROWS_BOUND));
        send_idle_pct = 0;
        recv_stall_pct = 68;
        long_hold_len = LONG_HOLD_CYCLES;
        send_random(25);
        wait_drained();

        set_shape(CFG_DATA_W'($urandom_range(1, 9)) | (CFG_DATA_W'($urandom_range(255)) << 17),
                  CFG_DATA_W'($urandom_range(500, 60000)));
        send_idle_pct = 30;
        recv_stall_pct = 30;
        send_random(30);
        wait_drained();

        if (!stream_halted && !matrix_complete)
        begin
            // Shrink the matrix so that it closes k lines from here, then count the
            // bytes needed to get there.
            ic = row_fastest ? row_ctr : col_ctr;
            oc = row_fastest ? col_ctr : row_ctr;
            inner = $urandom_range(1, 6);
            k = (ending == END_TRUNCATED) ? $urandom_range(2, 3) : $urandom_range(1, 3);
            set_shape(CFG_DATA_W'(inner), CFG_DATA_W'(oc + k));
            needed = 0;
            lines = 0;
            while (lines < k)
            begin
                needed++;
                span = (ic < inner) ? inner - ic : 1;
                if (span <= 4)
                begin
                    ic = 0;
                    lines++;
                end
                else
                begin
                    ic += 4;
                end
            end
            last_at = (ending == END_TRUNCATED) ? $urandom_range(1, needed - 1) : needed;
            for (int i = 1; i <= last_at; i++)
            begin
                push_byte(DATA_W'($urandom_range(255)),
                          i == last_at && (ending == END_TRUNCATED || $urandom_range(1)));
            end
        end
        for (int i = 0; i < 12; i++)
        begin
            push_byte(DATA_W'($urandom_range(255)), 1'($urandom_range(1)));
        end
        wait_drained();

        $display("Run covered %0d file bytes and %0d checked results, %s order, stream end %s.",
                 bytes_accepted, results_checked,
                 row_fastest ? "row-fastest" : "column-fastest", ending.name());
        $display("Shapes went from register extremes to short lines under four idling mixes.");
        if (mismatches == 0)
        begin
            $display("PASS bed_genotype_unpacker");
        end
        else
        begin
            $display("FAIL bed_genotype_unpacker");
        end
        $finish;
    end

    initial
    begin : watchdog
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("FAIL bed_genotype_unpacker");
        $finish;
    end

endmodule
